/* rtl/okc_pkg.sv */
package okc_pkg;

    localparam int NUM_CLUSTERS = 16;
    localparam int NUM_FEATURES = 16;
    localparam int NUM_CLASSES  = 16;

    localparam int CB   = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
    localparam int FB   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int KB   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int SB   = $clog2(NUM_CLUSTERS + 1);
    localparam int CA_W = (NUM_CLUSTERS * NUM_FEATURES > 1) ?
                          $clog2(NUM_CLUSTERS * NUM_FEATURES) : 1;
    localparam int KA_W = (NUM_CLUSTERS * NUM_CLASSES > 1) ?
                          $clog2(NUM_CLUSTERS * NUM_CLASSES) : 1;

    localparam int QDEPTH = 2;

    localparam logic [35:0] DIST_MAX  = {36{1'b1}};
    localparam logic [31:0] COUNT_MAX = {32{1'b1}};

    typedef enum logic [1:0] {
        FN_SEED     = 2'd0,
        FN_TRAIN    = 2'd1,
        FN_CLASSIFY = 2'd2,
        FN_DROP     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DROP  = 2'd2
    } t_status;

    typedef enum logic {
        REG_METRIC = 1'b0,
        REG_LIMIT  = 1'b1
    } t_reg;

    // one buffered point, as handed from front to back
    typedef struct packed {
        t_func                         func;
        logic [KB-1:0]                 lab;
        logic [NUM_FEATURES-1:0][15:0] pt;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  cluster_index;
        logic [35:0] min_distance;
        logic [3:0]  cluster_class;
        logic        label_match;
        t_status     status;
    } t_res;

endpackage

/* rtl/online_kmeans_cluster_classifier_unit.sv */
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+-------------------------------------
// input    | in        | i_in_valid / o_in_stall    | func, feature, last_feature, label
// result   | out       | o_out_valid / i_out_stall  | cluster_index, min_distance,
//          |           |                            |   cluster_class, label_match, status
// config   | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// Element words are taken one a cycle while the two-entry point queue has room.
// Back end works one point at a time: seed, classify over the S seeded clusters
// (one centroid read a cycle), train adds the per-feature restoring divide
// plus the label vote.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result leaves the back end free to finish into its result register.
module online_kmeans_cluster_classifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_feature,
    input  logic        i_last_feature,
    input  logic [3:0]  i_label,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_cluster_index,
    output logic [35:0] o_min_distance,
    output logic [3:0]  o_cluster_class,
    output logic        o_label_match,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    import okc_pkg::*;

    logic push, pop, q_empty, q_full;
    t_cmd cmd, head;
    t_res res;

    // front: element buffering, stalled only while the queue is full
    assign o_in_stall = q_full;

    okc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_full         (q_full),
        .i_func         (i_func),
        .i_feature      (i_feature),
        .i_last_feature (i_last_feature),
        .i_label        (i_label),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    okc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: nearest search, centroid update, vote, result register
    okc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_head    (head),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_cluster_index = res.cluster_index;
    assign o_min_distance  = res.min_distance;
    assign o_cluster_class = res.cluster_class;
    assign o_label_match   = res.label_match;
    assign o_status        = res.status;

endmodule

/* rtl/okc_front.sv */
module okc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_full,
    input  logic [1:0]    i_func,
    input  logic [15:0]   i_feature,
    input  logic          i_last_feature,
    input  logic [3:0]    i_label,
    output logic          o_push,
    output okc_pkg::t_cmd o_cmd
);
    import okc_pkg::*;

    logic [NUM_FEATURES-1:0][15:0] r_buf;
    logic [FB-1:0]                 r_idx;
    logic                          acc;

    assign acc = i_valid && !i_full;

    always_comb begin
        o_cmd.func = t_func'(i_func);
        o_cmd.lab  = (32'(i_label) >= NUM_CLASSES) ? KB'(NUM_CLASSES - 1) : KB'(i_label);
        for (int f = 0; f < NUM_FEATURES; f++) begin
            if (f < int'(r_idx))
                o_cmd.pt[f] = r_buf[f];
            else if (f == int'(r_idx))
                o_cmd.pt[f] = i_feature;
            else
                o_cmd.pt[f] = '0;  // element never received
        end
    end

    assign o_push = acc && i_last_feature && (t_func'(i_func) != FN_DROP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (acc) begin
            r_buf[r_idx] <= i_feature;
            if (i_last_feature)
                r_idx <= '0;
            else if (int'(r_idx) < NUM_FEATURES - 1)
                r_idx <= r_idx + 1'b1;
        end
    end

endmodule

/* rtl/okc_queue.sv */
module okc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  okc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output okc_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import okc_pkg::*;

    localparam int PB = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_cmd              r_mem [QDEPTH];
    logic [PB-1:0]     r_wp;
    logic [PB-1:0]     r_rp;
    logic [PB:0]       r_cnt;
    logic              do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PB+1)'(QDEPTH));
    assign o_head  = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp <= (int'(r_wp) == QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop)
                r_rp <= (int'(r_rp) == QDEPTH - 1) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (PB+1)'(i_push) - (PB+1)'(do_pop);
        end
    end

endmodule

/* rtl/okc_back.sv */
module okc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [4:0]    i_cfg_data,
    input  logic          i_q_empty,
    input  okc_pkg::t_cmd i_q_head,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output okc_pkg::t_res o_res
);
    import okc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SEEDC, S_SEEDK, S_DIST, S_DRAIN, S_POST, S_UPREP, S_URD,
        S_UWAIT, S_UDIV, S_UWR, S_CRD, S_CWAIT, S_ELECT, S_EDRAIN, S_RES
    } t_state;

    t_state                        r_state;
    logic                          r_metric;
    logic [4:0]                    r_limit;
    logic [SB-1:0]                 r_seeded;
    t_func                         r_func;
    logic [KB-1:0]                 r_lab;
    logic [NUM_FEATURES-1:0][15:0] r_x;
    logic [CB-1:0]                 r_c;
    logic [FB-1:0]                 r_f;
    logic [KB-1:0]                 r_k;
    logic [CB-1:0]                 r_best;
    logic [35:0]                   r_bd;
    logic [35:0]                   r_acc;
    logic                          r_p1_v, r_p1_end, r_p1_fin;
    logic [FB-1:0]                 r_p1_f;
    logic [CB-1:0]                 r_p1_c;
    logic                          r_p2_v, r_p2_end, r_p2_fin;
    logic [31:0]                   r_term;
    logic [CB-1:0]                 r_p2_c;
    logic [31:0]                   r_mcnt [NUM_CLUSTERS];
    logic [KB-1:0]                 r_maj  [NUM_CLUSTERS];
    logic [32:0]                   r_div;
    logic [15:0]                   r_rem;
    logic [15:0]                   r_quo;
    logic                          r_neg;
    logic [15:0]                   r_cold;
    logic [3:0]                    r_step;
    logic [31:0]                   r_freq;
    logic [KB-1:0]                 r_kbest;
    logic                          r_e_v, r_e_last;
    logic [KB-1:0]                 r_e_k;
    t_res                          r_res;
    logic                          r_o_valid;
    t_res                          r_o;

    // centroid and class-count stores
    logic [15:0] r_cent [NUM_CLUSTERS*NUM_FEATURES];
    logic [15:0] r_cent_q;
    logic [31:0] r_ccnt [NUM_CLUSTERS*NUM_CLASSES];
    logic [31:0] r_ccnt_q;

    logic            cent_we;
    logic [CB-1:0]   cent_c;
    logic [15:0]     cent_wd;
    logic [CA_W-1:0] cent_a;
    logic            cc_we;
    logic [CB-1:0]   cc_c;
    logic [KB-1:0]   cc_k;
    logic [31:0]     cc_wd;
    logic [KA_W-1:0] cc_a;

    logic [FB-1:0]   xi;
    logic [15:0]     x_val;
    logic [15:0]     dd;
    logic [31:0]     term;
    logic [36:0]     acc_sum;
    logic [35:0]     acc_sat;
    logic [16:0]     rem_sh;
    logic            ge;
    logic [32:0]     rem_n;
    logic [15:0]     new_c;
    logic            lim_hit;
    logic [CB-1:0]   seed_c;
    logic [KB-1:0]   maj_fin;
    int              lim;

    assign seed_c = CB'(r_seeded);
    assign xi     = (r_state == S_DIST || r_state == S_DRAIN) ? r_p1_f : r_f;
    assign x_val  = r_x[xi];

    assign dd   = (r_cent_q > x_val) ? r_cent_q - x_val : x_val - r_cent_q;
    assign term = r_metric ? 32'(dd) : 32'(dd) * 32'(dd);

    assign acc_sum = 37'(r_acc) + 37'(r_term);
    assign acc_sat = acc_sum[36] ? DIST_MAX : acc_sum[35:0];

    // restoring divide step
    assign rem_sh = {1'b0, r_rem} << 1 | 17'(r_quo[15]);
    assign ge     = (33'(rem_sh) >= r_div);
    assign rem_n  = ge ? 33'(rem_sh) - r_div : 33'(rem_sh);
    assign new_c  = r_neg ? r_cold - r_quo - 16'(r_rem != '0) : r_cold + r_quo;

    assign lim     = (int'(r_limit) > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(r_limit);
    assign lim_hit = int'(r_seeded) >= lim;

    assign maj_fin = (r_ccnt_q > r_freq) ? r_e_k : r_kbest;

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_out_valid = r_o_valid;
    assign o_res       = r_o;

    always_comb begin
        cent_we = 1'b0;
        cent_c  = r_best;
        cent_wd = new_c;
        cc_we   = 1'b0;
        cc_c    = r_best;
        cc_k    = r_k;
        cc_wd   = (r_ccnt_q == COUNT_MAX) ? r_ccnt_q : r_ccnt_q + 32'd1;
        case (r_state)
            S_SEEDC: begin
                cent_we = 1'b1;
                cent_c  = seed_c;
                cent_wd = x_val;
            end
            S_SEEDK: begin
                cc_we = 1'b1;
                cc_c  = seed_c;
                cc_wd = (r_k == r_lab) ? 32'd1 : 32'd0;
            end
            S_DIST:  cent_c = r_c;
            S_UWR:   cent_we = 1'b1;
            S_CRD:   cc_k = r_lab;
            S_CWAIT: begin
                cc_we = 1'b1;
                cc_k  = r_lab;
            end
            default: ;
        endcase
        cent_a = CA_W'(int'(cent_c) * NUM_FEATURES + int'(r_f));
        cc_a   = KA_W'(int'(cc_c) * NUM_CLASSES + int'(cc_k));
    end

    always_ff @(posedge i_clk) begin
        if (cent_we)
            r_cent[cent_a] <= cent_wd;
        r_cent_q <= r_cent[cent_a];
    end

    always_ff @(posedge i_clk) begin
        if (cc_we)
            r_ccnt[cc_a] <= cc_wd;
        r_ccnt_q <= r_ccnt[cc_a];
    end

    // distance pipeline payload: read, term, accumulate
    always_ff @(posedge i_clk) begin
        r_p1_f   <= r_f;
        r_p1_c   <= r_c;
        r_p1_end <= (r_f == FB'(NUM_FEATURES - 1));
        r_p1_fin <= (r_f == FB'(NUM_FEATURES - 1)) && (int'(r_c) == int'(r_seeded) - 1);
        r_term   <= term;
        r_p2_c   <= r_p1_c;
        r_p2_end <= r_p1_end;
        r_p2_fin <= r_p1_fin;
        r_e_k    <= r_k;
        r_e_last <= (r_k == KB'(NUM_CLASSES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_metric  <= 1'b0;
            r_limit   <= 5'd16;
            r_seeded  <= '0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_e_v     <= 1'b0;
            r_o_valid <= 1'b0;
            for (int c = 0; c < NUM_CLUSTERS; c++) begin
                r_mcnt[c] <= '0;
                r_maj[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_METRIC: r_metric <= i_cfg_data[0];
                    REG_LIMIT:  r_limit  <= i_cfg_data;
                    default: ;
                endcase
            end

            r_p1_v <= (r_state == S_DIST);
            r_p2_v <= r_p1_v;
            r_e_v  <= (r_state == S_ELECT);

            if (r_p2_v) begin
                if (r_p2_end) begin
                    r_acc <= '0;
                    if (r_p2_c == '0 || acc_sat < r_bd) begin
                        r_bd   <= acc_sat;
                        r_best <= r_p2_c;
                    end
                end else begin
                    r_acc <= acc_sat;
                end
            end

            if (r_e_v && r_ccnt_q > r_freq) begin
                r_freq  <= r_ccnt_q;
                r_kbest <= r_e_k;
            end

            // in S_RES the result register is reloaded below instead
            if (r_o_valid && !i_out_stall && r_state != S_RES)
                r_o_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_func <= i_q_head.func;
                        r_lab  <= i_q_head.lab;
                        r_x    <= i_q_head.pt;
                        r_f    <= '0;
                        r_c    <= '0;
                        r_acc  <= '0;
                        if (i_q_head.func == FN_SEED) begin
                            if (lim_hit) begin
                                r_res   <= '{4'd0, 36'd0, 4'd0, 1'b0, ST_DROP};
                                r_state <= S_RES;
                            end else begin
                                r_state <= S_SEEDC;
                            end
                        end else if (r_seeded == '0) begin
                            r_res   <= '{4'd0, 36'd0, 4'd0, 1'b0, ST_EMPTY};
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_SEEDC: begin
                    r_f <= r_f + 1'b1;
                    if (r_f == FB'(NUM_FEATURES - 1)) begin
                        r_k     <= '0;
                        r_state <= S_SEEDK;
                    end
                end
                S_SEEDK: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == KB'(NUM_CLASSES - 1)) begin
                        r_maj[seed_c]  <= r_lab;
                        r_mcnt[seed_c] <= 32'd1;
                        r_seeded       <= r_seeded + 1'b1;
                        r_res   <= '{4'(seed_c), 36'd0, 4'(r_lab), 1'b1, ST_OK};
                        r_state <= S_RES;
                    end
                end
                S_DIST: begin
                    if (r_f == FB'(NUM_FEATURES - 1)) begin
                        r_f <= '0;
                        if (int'(r_c) == int'(r_seeded) - 1)
                            r_state <= S_DRAIN;
                        else
                            r_c <= r_c + 1'b1;
                    end else begin
                        r_f <= r_f + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_p2_v && r_p2_fin)
                        r_state <= S_POST;
                end
                S_POST: begin
                    if (r_func == FN_TRAIN) begin
                        r_state <= S_UPREP;
                    end else begin
                        r_res   <= '{4'(r_best), r_bd, 4'(r_maj[r_best]),
                                     r_maj[r_best] == r_lab, ST_OK};
                        r_state <= S_RES;
                    end
                end
                S_UPREP: begin
                    r_div <= 33'(r_mcnt[r_best]) + 33'd1;
                    if (r_mcnt[r_best] != COUNT_MAX)
                        r_mcnt[r_best] <= r_mcnt[r_best] + 32'd1;
                    r_f     <= '0;
                    r_state <= S_URD;
                end
                S_URD: r_state <= S_UWAIT;
                S_UWAIT: begin
                    r_cold  <= r_cent_q;
                    r_neg   <= x_val < r_cent_q;
                    r_quo   <= (x_val < r_cent_q) ? r_cent_q - x_val : x_val - r_cent_q;
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_UDIV;
                end
                S_UDIV: begin
                    r_rem  <= rem_n[15:0];
                    r_quo  <= {r_quo[14:0], ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15)
                        r_state <= S_UWR;
                end
                S_UWR: begin
                    if (r_f == FB'(NUM_FEATURES - 1)) begin
                        r_state <= S_CRD;
                    end else begin
                        r_f     <= r_f + 1'b1;
                        r_state <= S_URD;
                    end
                end
                S_CRD: r_state <= S_CWAIT;
                S_CWAIT: begin
                    r_k     <= '0;
                    r_freq  <= '0;
                    r_kbest <= '0;
                    r_state <= S_ELECT;
                end
                S_ELECT: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == KB'(NUM_CLASSES - 1))
                        r_state <= S_EDRAIN;
                end
                S_EDRAIN: begin
                    if (r_e_v && r_e_last) begin
                        r_maj[r_best] <= maj_fin;
                        r_res   <= '{4'(r_best), r_bd, 4'(maj_fin), maj_fin == r_lab, ST_OK};
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o       <= r_res;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/okc_checker.sv */
module okc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_cluster_index,
    input logic [35:0] o_min_distance,
    input logic        o_label_match,
    input logic [1:0]  o_status
);
    import okc_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_min_distance) && $stable(o_status))
        else $error("result word changed under stall");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_cluster_index == 4'd0 && o_min_distance == 36'd0 && !o_label_match)
        else $error("failed step carries data");

endmodule

bind online_kmeans_cluster_classifier_unit okc_checker u_okc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_cluster_index (o_cluster_index),
    .o_min_distance  (o_min_distance),
    .o_label_match   (o_label_match),
    .o_status        (o_status)
);

/* bench/kmeans_checker.sv */
import okc_pkg::*;

module kmeans_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_feature,
    input  logic        i_last_feature,
    input  logic [3:0]  i_label,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_cluster_index,
    input  logic [35:0] i_min_distance,
    input  logic [3:0]  i_cluster_class,
    input  logic        i_label_match,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic        metric;
    logic [4:0]  limit;
    logic [15:0] pbuf [NUM_FEATURES];
    int unsigned elem_pos;
    logic [15:0] cent [NUM_CLUSTERS][NUM_FEATURES];
    logic [31:0] members [NUM_CLUSTERS];
    logic [31:0] votes [NUM_CLUSTERS][NUM_CLASSES];
    logic [3:0]  majority [NUM_CLUSTERS];
    int unsigned n_seeded;
    t_res        expected_results [$];

    assign o_pending = expected_results.size();

    task automatic report(input string what, input logic [35:0] got, input logic [35:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        o_errors++;
    endtask

    function automatic logic [35:0] distance(int c, logic [15:0] x [NUM_FEATURES]);
        logic [39:0] sum;
        logic [16:0] d;
        sum = '0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
            d = (cent[c][f] > x[f]) ? 17'(cent[c][f] - x[f]) : 17'(x[f] - cent[c][f]);
            sum += metric ? 40'(d) : 40'(d) * 40'(d);
        end
        return (sum > 40'(DIST_MAX)) ? DIST_MAX : sum[35:0];
    endfunction

    // close off a point and work out its result word
    task automatic finish_point(input t_func fn, input logic [3:0] lab);
        logic [15:0] x [NUM_FEATURES];
        logic [35:0] d, bd;
        logic [47:0] s;
        logic [31:0] freq;
        int          c, lim;
        t_res        r;
        for (int f = 0; f < NUM_FEATURES; f++)
            x[f] = (f <= elem_pos) ? pbuf[f] : 16'd0;
        elem_pos = 0;
        if (fn == FN_DROP) return;
        r = '0;
        if (fn == FN_SEED) begin
            lim = (limit > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(limit);
            if (n_seeded >= lim) begin
                r.status = ST_DROP;
            end else begin
                c = n_seeded;
                for (int f = 0; f < NUM_FEATURES; f++) cent[c][f] = x[f];
                members[c] = 32'd1;
                for (int k = 0; k < NUM_CLASSES; k++) votes[c][k] = '0;
                votes[c][lab] = 32'd1;
                majority[c] = lab;
                n_seeded++;
                r.cluster_index = 4'(c);
                r.cluster_class = lab;
                r.label_match = 1'b1;
            end
        end else if (n_seeded == 0) begin
            r.status = ST_EMPTY;
        end else begin
            c = 0;
            bd = '0;
            for (int k = 0; k < n_seeded; k++) begin
                d = distance(k, x);
                if (k == 0 || d < bd) begin
                    bd = d;
                    c = k;
                end
            end
            if (fn == FN_TRAIN) begin
                for (int f = 0; f < NUM_FEATURES; f++) begin
                    s = 48'(cent[c][f]) * 48'(members[c]) + 48'(x[f]);
                    cent[c][f] = 16'(s / (48'(members[c]) + 48'd1));
                end
                if (members[c] != COUNT_MAX) members[c]++;
                if (votes[c][lab] != COUNT_MAX) votes[c][lab]++;
                freq = '0;
                majority[c] = '0;
                for (int k = 0; k < NUM_CLASSES; k++)
                    if (votes[c][k] > freq) begin
                        freq = votes[c][k];
                        majority[c] = 4'(k);
                    end
            end
            r.cluster_index = 4'(c);
            r.min_distance = bd;
            r.cluster_class = majority[c];
            r.label_match = (majority[c] == lab);
        end
        expected_results = {expected_results, r};
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (!i_rst_n) begin
            metric = 1'b0;
            limit = 5'd16;
            elem_pos = 0;
            n_seeded = 0;
            o_errors = 0;
            for (int c = 0; c < NUM_CLUSTERS; c++) begin
                members[c] = '0;
                majority[c] = '0;
                for (int k = 0; k < NUM_CLASSES; k++) votes[c][k] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (t_reg'(i_cfg_idx) == REG_METRIC) metric = i_cfg_data[0];
                else limit = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                pbuf[elem_pos] = i_feature;
                if (i_last_feature) finish_point(t_func'(i_func), i_label);
                else if (elem_pos < NUM_FEATURES - 1) elem_pos++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result word");
                    o_errors++;
                end else begin
                    w = expected_results.pop_front();
                    if (i_cluster_index != w.cluster_index)
                        report("cluster_index", i_cluster_index, w.cluster_index);
                    if (i_min_distance != w.min_distance)
                        report("min_distance", i_min_distance, w.min_distance);
                    if (i_cluster_class != w.cluster_class)
                        report("cluster_class", i_cluster_class, w.cluster_class);
                    if (i_label_match != w.label_match)
                        report("label_match", i_label_match, w.label_match);
                    if (i_status != w.status)
                        report("status", i_status, w.status);
                end
            end
        end
    end

endmodule

/* bench/testbench.sv */
import okc_pkg::*;

module testbench;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = 2'd0;
    logic [15:0] feature = 16'd0;
    logic        last_feature = 1'b0;
    logic [3:0]  label = 4'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  cluster_index;
    logic [35:0] min_distance;
    logic [3:0]  cluster_class;
    logic        label_match;
    logic [1:0]  status;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [4:0]  cfg_data = 5'd0;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          stall_mode = 0;

    // worst case: 16 clusters with train points, plus stalls
    localparam int CYCLE_LIMIT = 1_500_000;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    online_kmeans_cluster_classifier_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_feature(feature), .i_last_feature(last_feature),
        .i_label(label),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_cluster_index(cluster_index), .o_min_distance(min_distance),
        .o_cluster_class(cluster_class), .o_label_match(label_match),
        .o_status(status),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    kmeans_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_feature(feature), .i_last_feature(last_feature),
        .i_label(label),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_cluster_index(cluster_index), .i_min_distance(min_distance),
        .i_cluster_class(cluster_class), .i_label_match(label_match),
        .i_status(status),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure: mode 0 never stalls, 1 light, 2 heavy,
    // 3 periodic bursts
    always @(posedge clk) begin
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_stall <= (cycles % 23) < 9;
            end
        endcase
    end

    int gap_left = 0;
    int burst_left = 0;

    // one element word; sender gaps come in random bursts
    task automatic send_word(input logic [1:0] fn, input logic [15:0] ft,
                             input logic lst, input logic [3:0] lb);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end
        while (gap_left > 0) begin
            in_valid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= fn;
        feature <= ft;
        last_feature <= lst;
        label <= lb;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(32768 + $urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_point(input t_func fn, input int len, input logic [3:0] lb,
                              input int style);
        logic [15:0] v;
        for (int k = 0; k < len; k++) begin
            case (style)
                0: v = 16'h0000;
                1: v = 16'hFFFF;
                default: v = pick_value();
            endcase
            send_word(fn, v, k == len - 1, lb);
        end
    endtask

    task automatic write_reg(input t_reg idx, input logic [4:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n_points, input int max_len);
        t_func fn;
        int    r;
        for (int p = 0; p < n_points; p++) begin
            r = $urandom_range(0, 19);
            if (r < 3) fn = FN_SEED;
            else if (r < 12) fn = FN_TRAIN;
            else if (r < 19) fn = FN_CLASSIFY;
            else fn = FN_DROP;
            send_point(fn, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20)
                           : $urandom_range(1, max_len),
                       4'($urandom), 2);
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty model first, then seeds at the extremes
        send_point(FN_TRAIN, 16, 4'd3, 2);
        send_point(FN_CLASSIFY, 16, 4'd15, 2);
        send_point(FN_DROP, 4, 4'd1, 2);
        send_point(FN_SEED, 16, 4'd0, 0);
        send_point(FN_SEED, 16, 4'd15, 1);
        send_point(FN_CLASSIFY, 16, 4'd15, 1);  // square sum near the 36-bit maximum
        send_point(FN_TRAIN, 3, 4'd7, 2);        // short point
        send_point(FN_TRAIN, 19, 4'd7, 2);       // long point
        send_point(FN_CLASSIFY, 16, 4'd0, 0);

        write_reg(REG_METRIC, 5'd1);
        write_reg(REG_LIMIT, 5'd3);
        send_point(FN_SEED, 16, 4'd5, 2);
        send_point(FN_SEED, 16, 4'd6, 2);        // dropped at limit
        send_point(FN_CLASSIFY, 16, 4'd5, 1);
        send_point(FN_TRAIN, 16, 4'd9, 2);

        stall_mode = 1;
        random_phase(25, 4);
        write_reg(REG_LIMIT, 5'd0);
        stall_mode = 2;
        random_phase(20, 4);
        write_reg(REG_METRIC, 5'd0);
        write_reg(REG_LIMIT, 5'd31);
        stall_mode = 3;
        random_phase(40, 16);
        write_reg(REG_LIMIT, 5'd16);
        stall_mode = 0;
        random_phase(30, 4);
        write_reg(REG_METRIC, 5'd1);
        write_reg(REG_LIMIT, 5'd1);
        stall_mode = 1;
        random_phase(20, 6);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (700) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
